// ===== design/pva_pkg.sv =====
// shared types and constants for the voice allocator
`default_nettype none
package pva_pkg;

    localparam int NUM_VOICES_DEF = 16;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_STATUS = 2'd1;
    localparam logic [1:0] OP_PITCH  = 2'd2;

    localparam logic [1:0] REG_STEAL   = 2'd0;
    localparam logic [1:0] REG_PEDAL   = 2'd1;
    localparam logic [1:0] REG_DESCANT = 2'd2;

    localparam logic signed [7:0] PITCH_NONE = -8'sd1;

    typedef enum logic [1:0] {
        K_ALLOC  = 2'd0,
        K_STATUS = 2'd1,
        K_PITCH  = 2'd2,
        K_NOP    = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [6:0]        note;
        logic [3:0]        voice_sel;
        logic              set_active;
        logic              set_released;
        logic              set_key_down;
        logic signed [7:0] pedal_pitch;
        logic signed [7:0] descant_pitch;
    } t_cmd;

    typedef struct packed {
        logic steal_enable;
        logic pedal_enable;
        logic descant_enable;
    } t_cfg;

    typedef struct packed {
        logic [3:0] voice_index;
        logic       found;
        logic       stolen;
        logic       pedal_cleared;
        logic       descant_cleared;
    } t_res;

    function automatic logic pitch_hit(input logic signed [7:0] pitch,
                                       input logic [6:0] note);
        pitch_hit = !pitch[7] && (pitch[6:0] == note);
    endfunction

endpackage
`default_nettype wire

// ===== design/pva_if.sv =====
// request, response and register write channels
`default_nettype none
interface pva_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [6:0]        note;
    logic [3:0]        voice_sel;
    logic              set_active;
    logic              set_released;
    logic              set_key_down;
    logic signed [7:0] new_pedal_pitch;
    logic signed [7:0] new_descant_pitch;
    modport source (output valid, opcode, note, voice_sel, set_active, set_released,
                    set_key_down, new_pedal_pitch, new_descant_pitch, input ready);
    modport sink (input valid, opcode, note, voice_sel, set_active, set_released,
                  set_key_down, new_pedal_pitch, new_descant_pitch, output ready);
endinterface

interface pva_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] voice_index;
    logic       found;
    logic       stolen;
    logic       pedal_cleared;
    logic       descant_cleared;
    modport source (output valid, voice_index, found, stolen, pedal_cleared,
                    descant_cleared, input ready);
    modport sink (input valid, voice_index, found, stolen, pedal_cleared,
                  descant_cleared, output ready);
endinterface

interface pva_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic       data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/poly_voice_allocator.sv =====
// top level of the polyphonic voice allocator
// Each request is queued by the front end and run by the back end one at a time. A status
// or pitch write goes from idle straight to the output state; an allocate first checks for
// an idle voice, and a steal then runs one table scan for held-note extremes and auto
// voices, one oldest-first scan and a pick. Up to two requests queue ahead,
// and the result register lets the next request run while a result waits.
`default_nettype none
module poly_voice_allocator
    import pva_pkg::*;
#(
    parameter int NUM_VOICES = NUM_VOICES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pva_req_if.sink   i_req,
    pva_cfg_if.sink   i_cfg,
    pva_rsp_if.source o_rsp
);
    t_cfg r_cfg;
    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steal_enable   <= 1'b1;
            r_cfg.pedal_enable   <= 1'b0;
            r_cfg.descant_enable <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_STEAL:   r_cfg.steal_enable   <= i_cfg.data;
                REG_PEDAL:   r_cfg.pedal_enable   <= i_cfg.data;
                REG_DESCANT: r_cfg.descant_enable <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    pva_front #(.NUM_VOICES(NUM_VOICES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    pva_back #(.NUM_VOICES(NUM_VOICES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_rsp       (o_rsp)
    );
endmodule
`default_nettype wire

// ===== design/pva_front.sv =====
// request intake, decode and command queue
`default_nettype none
module pva_front
    import pva_pkg::*;
#(
    parameter int NUM_VOICES = NUM_VOICES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pva_req_if.sink   i_req,
    output t_cmd      o_cmd,
    output logic      o_cmd_valid,
    input  wire logic i_cmd_pop
);
    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       push;

    always_comb begin
        n_cmd.note          = i_req.note;
        n_cmd.voice_sel     = i_req.voice_sel;
        n_cmd.set_active    = i_req.set_active;
        n_cmd.set_released  = i_req.set_released;
        n_cmd.set_key_down  = i_req.set_key_down;
        n_cmd.pedal_pitch   = i_req.new_pedal_pitch;
        n_cmd.descant_pitch = i_req.new_descant_pitch;
        case (i_req.opcode)
            OP_ALLOC:  n_cmd.kind = K_ALLOC;
            OP_STATUS: n_cmd.kind = (7'(i_req.voice_sel) < 7'(NUM_VOICES)) ? K_STATUS : K_NOP;
            OP_PITCH:  n_cmd.kind = K_PITCH;
            default:   n_cmd.kind = K_NOP;
        endcase
    end

    assign i_req.ready = (r_cnt != 2'd2);
    assign push        = i_req.valid && i_req.ready;
    assign o_cmd       = r_q[r_rp];
    assign o_cmd_valid = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_pop);
        end
    end
endmodule
`default_nettype wire

// ===== design/pva_back.sv =====
// voice table, allocation scans and result register
`default_nettype none
module pva_back
    import pva_pkg::*;
#(
    parameter int NUM_VOICES = NUM_VOICES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire t_cmd i_cmd,
    input  wire logic i_cmd_valid,
    output logic      o_cmd_pop,
    pva_rsp_if.source o_rsp
);
    localparam int IW = $clog2(NUM_VOICES);
    localparam logic [IW-1:0] LAST = IW'(NUM_VOICES - 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FREE   = 6'b000010,
        S_MINMAX = 6'b000100,
        S_ORDER  = 6'b001000,
        S_PICK   = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state            r_state;
    t_cmd              r_cmd;
    logic [IW-1:0]     r_cnt;
    logic              r_active   [NUM_VOICES];
    logic [6:0]        r_note     [NUM_VOICES];
    logic              r_rel      [NUM_VOICES];
    logic              r_kd       [NUM_VOICES];
    logic [IW-1:0]     r_rank     [NUM_VOICES];
    logic [IW-1:0]     r_order    [NUM_VOICES];
    logic signed [7:0] r_ped;
    logic signed [7:0] r_des;
    logic              r_low_v, r_top_v, r_des_v, r_ped_v;
    logic [IW-1:0]     r_low_i, r_top_i, r_des_i, r_ped_i;
    logic [6:0]        r_low_n, r_top_n;
    logic [3:0]        r_c_v;
    logic [IW-1:0]     r_c_i      [4];
    t_res              r_res;
    t_res              r_ores;
    logic              r_ovalid;

    logic              free_v;
    logic [IW-1:0]     free_i;
    logic [IW-1:0]     sel_i;
    logic [IW-1:0]     mm_v;
    logic [IW-1:0]     ord_v;
    logic              prot_mm, prot_ord, lt;
    logic              pick_any;

    function automatic logic is_prot(input t_cfg cfg, input logic signed [7:0] ped,
                                     input logic signed [7:0] des, input logic [6:0] n);
        is_prot = (cfg.pedal_enable && pitch_hit(ped, n)) ||
                  (cfg.descant_enable && pitch_hit(des, n));
    endfunction

    always_comb begin
        free_v = 1'b0;
        free_i = '0;
        for (int v = NUM_VOICES - 1; v >= 0; v--) begin
            if (!r_active[v]) begin
                free_v = 1'b1;
                free_i = IW'(v);
            end
        end
    end

    assign sel_i    = IW'(i_cmd.voice_sel);
    assign mm_v     = r_cnt;
    assign ord_v    = r_order[r_cnt];
    assign prot_mm  = is_prot(i_cfg, r_ped, r_des, r_note[mm_v]);
    assign prot_ord = is_prot(i_cfg, r_ped, r_des, r_note[ord_v]);
    assign lt       = (r_low_v && ord_v == r_low_i) || (r_top_v && ord_v == r_top_i);
    assign pick_any = (r_c_v != 4'd0) || (i_cfg.descant_enable && r_des_v) ||
                      (i_cfg.pedal_enable && r_ped_v) || r_top_v || r_low_v;
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    assign o_rsp.valid           = r_ovalid;
    assign o_rsp.voice_index     = r_ores.voice_index;
    assign o_rsp.found           = r_ores.found;
    assign o_rsp.stolen          = r_ores.stolen;
    assign o_rsp.pedal_cleared   = r_ores.pedal_cleared;
    assign o_rsp.descant_cleared = r_ores.descant_cleared;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_ped    <= PITCH_NONE;
            r_des    <= PITCH_NONE;
            for (int v = 0; v < NUM_VOICES; v++) begin
                r_active[v] <= 1'b0;
                r_note[v]   <= '0;
                r_rel[v]    <= 1'b0;
                r_kd[v]     <= 1'b0;
                r_rank[v]   <= IW'(v);
                r_order[v]  <= IW'(v);
            end
        end else begin
            if (r_ovalid && o_rsp.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_res   <= '0;
                        r_state <= (i_cmd.kind == K_ALLOC) ? S_FREE : S_OUT;
                        case (i_cmd.kind)
                            K_ALLOC: begin
                            end
                            K_STATUS: begin
                                if (i_cmd.set_active && !r_active[sel_i]) begin
                                    for (int v = 0; v < NUM_VOICES; v++) begin
                                        if (r_rank[v] > r_rank[sel_i]) begin
                                            r_rank[v] <= r_rank[v] - 1'b1;
                                        end
                                    end
                                    r_rank[sel_i] <= LAST;
                                    for (int r = 0; r < NUM_VOICES - 1; r++) begin
                                        if (IW'(r) >= r_rank[sel_i]) begin
                                            r_order[r] <= r_order[r+1];
                                        end
                                    end
                                    r_order[NUM_VOICES-1] <= sel_i;
                                end
                                r_active[sel_i] <= i_cmd.set_active;
                                r_note[sel_i]   <= i_cmd.note;
                                r_rel[sel_i]    <= i_cmd.set_released;
                                r_kd[sel_i]     <= i_cmd.set_key_down;
                            end
                            K_PITCH: begin
                                r_ped <= i_cmd.pedal_pitch;
                                r_des <= i_cmd.descant_pitch;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_FREE: begin
                    r_cnt   <= '0;
                    r_low_v <= 1'b0;
                    r_top_v <= 1'b0;
                    r_des_v <= 1'b0;
                    r_ped_v <= 1'b0;
                    r_c_v   <= '0;
                    if (free_v) begin
                        r_res.voice_index <= 4'(free_i);
                        r_res.found       <= 1'b1;
                        r_state           <= S_OUT;
                    end else if (i_cfg.steal_enable) begin
                        r_state <= S_MINMAX;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_MINMAX: begin
                    if (!prot_mm && r_active[mm_v] && !r_rel[mm_v]) begin
                        if (!r_low_v || r_note[mm_v] < r_low_n) begin
                            r_low_v <= 1'b1;
                            r_low_i <= mm_v;
                            r_low_n <= r_note[mm_v];
                        end
                        if (!r_top_v || r_note[mm_v] > r_top_n) begin
                            r_top_v <= 1'b1;
                            r_top_i <= mm_v;
                            r_top_n <= r_note[mm_v];
                        end
                    end
                    if (!r_des_v && r_active[mm_v] && pitch_hit(r_des, r_note[mm_v])) begin
                        r_des_v <= 1'b1;
                        r_des_i <= mm_v;
                    end
                    if (!r_ped_v && r_active[mm_v] && pitch_hit(r_ped, r_note[mm_v])) begin
                        r_ped_v <= 1'b1;
                        r_ped_i <= mm_v;
                    end
                    r_cnt <= (r_cnt == LAST) ? '0 : r_cnt + 1'b1;
                    if (r_cnt == LAST) begin
                        r_state <= S_ORDER;
                    end
                end
                S_ORDER: begin
                    if (r_cnt == '0 && r_top_v && r_low_v && r_top_i == r_low_i) begin
                        r_top_v <= 1'b0;
                    end
                    if (!prot_ord) begin
                        if (!r_c_v[0] && r_note[ord_v] == r_cmd.note) begin
                            r_c_v[0] <= 1'b1;
                            r_c_i[0] <= ord_v;
                        end
                        if (!r_c_v[1] && !lt && r_rel[ord_v]) begin
                            r_c_v[1] <= 1'b1;
                            r_c_i[1] <= ord_v;
                        end
                        if (!r_c_v[2] && !lt && !r_kd[ord_v]) begin
                            r_c_v[2] <= 1'b1;
                            r_c_i[2] <= ord_v;
                        end
                        if (!r_c_v[3] && !lt) begin
                            r_c_v[3] <= 1'b1;
                            r_c_i[3] <= ord_v;
                        end
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST) begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    r_res.found  <= pick_any;
                    r_res.stolen <= pick_any;
                    r_state      <= S_OUT;
                    if (r_c_v[0]) begin
                        r_res.voice_index <= 4'(r_c_i[0]);
                    end else if (r_c_v[1]) begin
                        r_res.voice_index <= 4'(r_c_i[1]);
                    end else if (r_c_v[2]) begin
                        r_res.voice_index <= 4'(r_c_i[2]);
                    end else if (r_c_v[3]) begin
                        r_res.voice_index <= 4'(r_c_i[3]);
                    end else if (i_cfg.descant_enable && r_des_v) begin
                        r_res.voice_index     <= 4'(r_des_i);
                        r_res.descant_cleared <= 1'b1;
                        r_des                 <= PITCH_NONE;
                    end else if (i_cfg.pedal_enable && r_ped_v) begin
                        r_res.voice_index   <= 4'(r_ped_i);
                        r_res.pedal_cleared <= 1'b1;
                        r_ped               <= PITCH_NONE;
                    end else if (r_top_v) begin
                        r_res.voice_index <= 4'(r_top_i);
                    end else if (r_low_v) begin
                        r_res.voice_index <= 4'(r_low_i);
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ores   <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_stolen_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (!r_ores.stolen || r_ores.found))
        else $error("stolen without a voice");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_ores.found) |-> (r_ores.voice_index == 4'd0 &&
            !r_ores.pedal_cleared && !r_ores.descant_cleared))
        else $error("fields set on empty result");

    a_one_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !(r_ores.pedal_cleared && r_ores.descant_cleared))
        else $error("both auto pitches cleared");

    a_clear_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK && r_res.found == 1'b0) ##1 r_res.descant_cleared
            |-> r_des == PITCH_NONE)
        else $error("descant pitch not cleared");
endmodule
`default_nettype wire

// ===== tb/tb_pva_scoreboard.sv =====
// voice table predictor and result checker for the voice allocator testbench
`timescale 1ns / 1ps
class pva_scoreboard;
    localparam int NV = 16;
    localparam int NONE = 255;

    bit               steal_en;
    bit               pedal_en;
    bit               descant_en;
    bit               v_active [NV];
    bit [6:0]         v_note [NV];
    bit               v_rel [NV];
    bit               v_key [NV];
    int               v_rank [NV];
    logic signed [7:0] ped_pitch;
    logic signed [7:0] des_pitch;
    pva_pkg::t_res    pending [$];
    int               errors;

    function new();
        steal_en = 1;
        pedal_en = 0;
        descant_en = 0;
        for (int v = 0; v < NV; v++) begin
            v_active[v] = 0;
            v_note[v] = 0;
            v_rel[v] = 0;
            v_key[v] = 0;
            v_rank[v] = v;
        end
        ped_pitch = -8'sd1;
        des_pitch = -8'sd1;
        errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, bit val);
        case (idx)
            pva_pkg::REG_STEAL: begin
                steal_en = val;
            end
            pva_pkg::REG_PEDAL: begin
                pedal_en = val;
            end
            pva_pkg::REG_DESCANT: begin
                descant_en = val;
            end
            default: begin
            end
        endcase
    endfunction

    function bit note_is(logic signed [7:0] p, bit [6:0] n);
        return !p[7] && p[6:0] == n;
    endfunction

    function bit guarded(int v);
        return (pedal_en && note_is(ped_pitch, v_note[v])) ||
               (descant_en && note_is(des_pitch, v_note[v]));
    endfunction

    function int auto_owner(logic signed [7:0] p);
        for (int v = 0; v < NV; v++)
            if (v_active[v] && note_is(p, v_note[v])) return v;
        return NONE;
    endfunction

    function int pick_victim(bit [6:0] n, output bit pc, output bit dc);
        int order [NV];
        int cand [$];
        int low;
        int top;
        int v;
        low = NONE;
        top = NONE;
        pc = 0;
        dc = 0;
        for (int i = 0; i < NV; i++) order[v_rank[i]] = i;
        for (int i = 0; i < NV; i++) begin
            if (!guarded(i) && v_active[i] && !v_rel[i]) begin
                if (low == NONE || v_note[i] < v_note[low]) low = i;
                if (top == NONE || v_note[i] > v_note[top]) top = i;
            end
        end
        if (top == low) top = NONE;
        for (int r = 0; r < NV; r++)
            if (!guarded(order[r])) cand.push_back(order[r]);
        foreach (cand[k]) if (v_note[cand[k]] == n) return cand[k];
        for (int p = 0; p < 3; p++) begin
            foreach (cand[k]) begin
                v = cand[k];
                if (v == low || v == top) continue;
                if (p == 0 && !v_rel[v]) continue;
                if (p == 1 && v_key[v]) continue;
                return v;
            end
        end
        if (descant_en) begin
            v = auto_owner(des_pitch);
            if (v != NONE) begin
                des_pitch = -8'sd1;
                dc = 1;
                return v;
            end
        end
        if (pedal_en) begin
            v = auto_owner(ped_pitch);
            if (v != NONE) begin
                ped_pitch = -8'sd1;
                pc = 1;
                return v;
            end
        end
        if (top != NONE) return top;
        return low;
    endfunction

    function void note_request(pva_pkg::t_cmd c);
        pva_pkg::t_res r;
        int idx;
        int old;
        bit pc;
        bit dc;
        bit st;
        idx = NONE;
        pc = 0;
        dc = 0;
        st = 0;
        case (c.kind)
            pva_pkg::K_ALLOC: begin
                for (int v = 0; v < NV; v++)
                    if (!v_active[v] && idx == NONE) idx = v;
                if (idx == NONE && steal_en) begin
                    idx = pick_victim(c.note, pc, dc);
                    st = idx != NONE;
                end
            end
            pva_pkg::K_STATUS: begin
                if (c.set_active && !v_active[c.voice_sel]) begin
                    old = v_rank[c.voice_sel];
                    for (int v = 0; v < NV; v++) if (v_rank[v] > old) v_rank[v]--;
                    v_rank[c.voice_sel] = NV - 1;
                end
                v_active[c.voice_sel] = c.set_active;
                v_note[c.voice_sel] = c.note;
                v_rel[c.voice_sel] = c.set_released;
                v_key[c.voice_sel] = c.set_key_down;
            end
            pva_pkg::K_PITCH: begin
                ped_pitch = c.pedal_pitch;
                des_pitch = c.descant_pitch;
            end
            default: begin
            end
        endcase
        r = '0;
        if (idx != NONE) begin
            r.voice_index = idx[3:0];
            r.found = 1;
            r.stolen = st;
            r.pedal_cleared = pc;
            r.descant_cleared = dc;
        end
        pending.push_back(r);
    endfunction

    function void report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endfunction

    function void check_result(pva_pkg::t_res got);
        pva_pkg::t_res want;
        if (pending.size() == 0) begin
            report("unexpected response", 1, 0);
            return;
        end
        want = pending.pop_front();
        if (got.found !== want.found) report("found", got.found, want.found);
        if (got.voice_index !== want.voice_index)
            report("voice_index", got.voice_index, want.voice_index);
        if (got.stolen !== want.stolen) report("stolen", got.stolen, want.stolen);
        if (got.pedal_cleared !== want.pedal_cleared)
            report("pedal_cleared", got.pedal_cleared, want.pedal_cleared);
        if (got.descant_cleared !== want.descant_cleared)
            report("descant_cleared", got.descant_cleared, want.descant_cleared);
    endfunction
endclass

// ===== tb/testbench.sv =====
// testbench top: drives requests and register writes, checks allocator responses
`timescale 1ns / 1ps
module testbench;
    import pva_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   burst_left;
    int   stall_mode;

    pva_req_if req_ch ();
    pva_cfg_if cfg_ch ();
    pva_rsp_if rsp_ch ();

    pva_scoreboard sb;

    poly_voice_allocator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // response check and receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result({rsp_ch.voice_index, rsp_ch.found, rsp_ch.stolen,
                             rsp_ch.pedal_cleared, rsp_ch.descant_cleared});
    end

    always @(negedge i_clk) begin
        case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
        if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
    end

    task automatic send_req(t_cmd c);
        if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.opcode <= c.kind;
        req_ch.note <= c.note;
        req_ch.voice_sel <= c.voice_sel;
        req_ch.set_active <= c.set_active;
        req_ch.set_released <= c.set_released;
        req_ch.set_key_down <= c.set_key_down;
        req_ch.new_pedal_pitch <= c.pedal_pitch;
        req_ch.new_descant_pitch <= c.descant_pitch;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(c);
        @(negedge i_clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, bit val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic set_regs(bit s, bit p, bit d);
        drain();
        write_reg(REG_STEAL, s);
        write_reg(REG_PEDAL, p);
        write_reg(REG_DESCANT, d);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_cmd mk(t_kind k, bit [6:0] n, bit [3:0] sel, bit a, bit r,
                                bit kd, logic signed [7:0] pp, logic signed [7:0] dp);
        t_cmd c;
        c.kind = k;
        c.note = n;
        c.voice_sel = sel;
        c.set_active = a;
        c.set_released = r;
        c.set_key_down = kd;
        c.pedal_pitch = pp;
        c.descant_pitch = dp;
        return c;
    endfunction

    // random item, mostly a filled table with allocates and status writes
    function automatic t_cmd rand_req(int notes_lo, int notes_hi);
        t_cmd c;
        int sel;
        c = mk(K_ALLOC, 7'($urandom_range(notes_lo, notes_hi)), 4'($urandom),
               1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
        sel = $urandom_range(0, 99);
        if (sel < 45) c.kind = K_ALLOC;
        else if (sel < 85) begin
            c.kind = K_STATUS;
            c.set_active = ($urandom_range(0, 9) != 0);
        end else if (sel < 95) begin
            c.kind = K_PITCH;
            if ($urandom_range(0, 2) == 0) c.pedal_pitch = -8'sd1;
            else if ($urandom_range(0, 1))
                c.pedal_pitch = 8'($urandom_range(notes_lo, notes_hi));
            if ($urandom_range(0, 2) == 0) c.descant_pitch = -8'sd1;
            else if ($urandom_range(0, 1))
                c.descant_pitch = 8'($urandom_range(notes_lo, notes_hi));
        end else c.kind = K_NOP;
        return c;
    endfunction

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int lo;
        int hi;
        sb = new();
        burst_left = 0;
        stall_mode = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.opcode = OP_ALLOC;
        req_ch.note = '0;
        req_ch.voice_sel = '0;
        req_ch.set_active = 1'b0;
        req_ch.set_released = 1'b0;
        req_ch.set_key_down = 1'b0;
        req_ch.new_pedal_pitch = PITCH_NONE;
        req_ch.new_descant_pitch = PITCH_NONE;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_STEAL;
        cfg_ch.data = 1'b1;
        rsp_ch.ready = 1'b1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty table, extremes, fill, pitches, steals
        send_req(mk(K_ALLOC, 7'd0, 4'd0, 0, 0, 0, 0, 0));
        send_req(mk(K_NOP, 7'd127, 4'd15, 1, 1, 1, 8'sd127, -8'sd1));
        for (int v = 0; v < 16; v++)
            send_req(mk(K_STATUS, (v == 15) ? 7'd127 : 7'(v * 5), 4'(v), 1, v % 3 == 0,
                        1'(v % 2), 0, 0));
        send_req(mk(K_ALLOC, 7'd127, 0, 0, 0, 0, 0, 0));
        send_req(mk(K_ALLOC, 7'd1, 0, 0, 0, 0, 0, 0));
        set_regs(1, 1, 1);
        send_req(mk(K_PITCH, 0, 0, 0, 0, 0, 8'sd10, 8'sd127));
        send_req(mk(K_ALLOC, 7'd2, 0, 0, 0, 0, 0, 0));
        send_req(mk(K_STATUS, 7'd3, 4'd3, 0, 0, 0, 0, 0));
        send_req(mk(K_ALLOC, 7'd3, 0, 0, 0, 0, 0, 0));
        send_req(mk(K_PITCH, 0, 0, 0, 0, 0, -8'sd1, -8'sd128));
        send_req(mk(K_ALLOC, 7'd4, 0, 0, 0, 0, 0, 0));
        set_regs(0, 0, 0);
        send_req(mk(K_ALLOC, 7'd5, 0, 0, 0, 0, 0, 0));

        // random phases over several register settings
        for (int ph = 0; ph < 9; ph++) begin
            set_regs(ph != 3, 1'($urandom), 1'($urandom));
            // narrow note ranges give frequent same-note and auto-pitch hits
            lo = (ph % 2) ? $urandom_range(0, 100) : 0;
            hi = (ph % 2) ? lo + $urandom_range(2, 27) : 127;
            if (ph == 4) stall_mode = 2;
            for (int i = 0; i < 100; i++) begin
                send_req(rand_req(lo, hi));
                if (i == 50 && ph == 5) drain();
            end
            stall_mode = $urandom_range(0, 2);
        end

        drain();
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
